FILE: hw/rtl/zcg_pkg.sv
package zcg_pkg;

   // field widths
   localparam int ROOT_W   = 10;
   localparam int INDEX_W  = 10;
   localparam int SLOT_W   = 6;
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 10;

   localparam int ROM_W      = 2 * SAMPLE_W;
   localparam int REQ_DATA_W = ((ROOT_W + INDEX_W + SLOT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * SAMPLE_W + SLOT_W + INDEX_W + 7) / 8) * 8;

   // bit-serial modular multiply: one multiplier bit per cycle
   localparam int MM_STEPS = INDEX_W;
   localparam int STEP_W   = $clog2(MM_STEPS);

   localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
   localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
   localparam logic [63:0] MASK30     = 64'h0000_0000_3FFF_FFFF;
   localparam logic [63:0] Q15_SCALE  = 64'd32767;

   typedef enum logic {
      MM_INV_K  = 1'b0,   // inv * k
      MM_SUCC_K = 1'b1    // (acc + 1) * k
   } zcg_mm_sel_type;

   typedef struct packed {
      logic           load;
      logic           check;
      logic           search;
      logic           reject;
      logic           mm_start;
      zcg_mm_sel_type mm_sel;
      logic           mm_step;
      logic           halve;
      logic           rom_read;
   } zcg_cmd_type;

   typedef struct packed {
      logic bad;
      logic hit;
      logic found;
      logic exhausted;
   } zcg_status_type;

   // first member lands in the high bits: real part ends up at bit 0
   typedef struct packed {
      logic        [INDEX_W-1:0]  index_out;
      logic        [SLOT_W-1:0]   slot_out;
      logic signed [SAMPLE_W-1:0] sample_imag;
      logic signed [SAMPLE_W-1:0] sample_real;
   } zcg_result_type;

   // ---------------------------------------------------------------
   // Elaboration-time helpers that build the phase ROM contents.
   // ---------------------------------------------------------------

   // restoring long division
   function automatic logic [63:0] zcg_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // (a*b) >> 60, truncated to 64 bits
   function automatic logic [63:0] zcg_mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // atan(1/x) in Q62
   function automatic logic [63:0] zcg_atan_inv_q62(input logic [63:0] x);
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] x2;
      logic [63:0] term;
      logic        done;
      t    = zcg_udiv(ONE_Q62, x);
      sum  = t;
      x2   = x * x;
      done = 1'b0;
      for (int n = 1; n < 64; n++) begin
         if (!done) begin
            t = zcg_udiv(t, x2);
            if (t == 64'd0) begin
               done = 1'b1;
            end else begin
               term = zcg_udiv(t, 64'(2 * n + 1));
               if ((n & 1) != 0) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
      end
      return sum;
   endfunction

   // Machin: pi/4 = 4*atan(1/5) - atan(1/239), Q62 -> pi/2 in Q60
   localparam logic [63:0] HALF_PI_Q60 =
      ((64'd4 * zcg_atan_inv_q62(64'd5)) - zcg_atan_inv_q62(64'd239)) >> 1;

   // Taylor sums, {cos, sin} in Q60; alternating sums wrap harmlessly
   function automatic logic [127:0] zcg_sincos_q60(input logic [63:0] a);
      logic [63:0] a2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] ss;
      logic [63:0] cc;
      a2 = zcg_mul_q60(a, a);
      ts = a;
      tc = ONE_Q60;
      ss = a;
      cc = ONE_Q60;
      for (int n = 1; n < 24; n++) begin
         tc = zcg_udiv(zcg_mul_q60(tc, a2), 64'((2 * n - 1) * (2 * n)));
         ts = zcg_udiv(zcg_mul_q60(ts, a2), 64'((2 * n) * (2 * n + 1)));
         if ((n & 1) != 0) begin
            cc = cc - tc;
            ss = ss - ts;
         end else begin
            cc = cc + tc;
            ss = ss + ts;
         end
      end
      return {cc, ss};
   endfunction

   // floor(32767 * m / 2^60), clamped; negative side is minus the ceiling
   function automatic logic [SAMPLE_W-1:0] zcg_scale_q15(input logic [63:0] m,
                                                         input logic negative);
      logic [63:0] mh;
      logic [63:0] ml;
      logic [63:0] plo;
      logic [63:0] acc;
      logic [63:0] mag;
      logic        inexact;
      mh      = m >> 30;
      ml      = m & MASK30;
      plo     = Q15_SCALE * ml;
      acc     = Q15_SCALE * mh + (plo >> 30);
      mag     = acc >> 30;
      inexact = (plo[29:0] != 30'd0) || (acc[29:0] != 30'd0);
      if (mag > Q15_SCALE) begin
         mag = Q15_SCALE;
      end
      if (negative) begin
         mag = mag + {63'd0, inexact};
         mag = 64'd0 - mag;
      end
      return mag[SAMPLE_W-1:0];
   endfunction

   // {imag, real} for phase index j of length n
   function automatic logic [ROM_W-1:0] zcg_sample_word(input logic [63:0] j,
                                                        input logic [63:0] n);
      logic [63:0]          x;
      logic [63:0]          q;
      logic [63:0]          rem;
      logic [63:0]          frac;
      logic [63:0]          ang;
      logic [127:0]         cs;
      logic [63:0]          re_m;
      logic [63:0]          im_m;
      logic [SAMPLE_W-1:0]  re;
      logic [SAMPLE_W-1:0]  im;
      x    = j << 2;
      q    = zcg_udiv(x, n);
      rem  = x - q * n;
      frac = 64'd0;
      for (int b = 0; b < 60; b++) begin
         rem  = rem << 1;
         frac = frac << 1;
         if (rem >= n) begin
            rem     = rem - n;
            frac[0] = 1'b1;
         end
      end
      ang = zcg_mul_q60(frac, HALF_PI_Q60);
      cs  = zcg_sincos_q60(ang);
      // odd quadrants swap sin and cos
      if (q[0]) begin
         re_m = cs[63:0];
         im_m = cs[127:64];
      end else begin
         re_m = cs[127:64];
         im_m = cs[63:0];
      end
      re = zcg_scale_q15(re_m, q[1] ^ q[0]);
      im = zcg_scale_q15(im_m, q[1]);
      return {im, re};
   endfunction

endpackage

FILE: hw/rtl/zcg_rom.sv
module zcg_rom
   import zcg_pkg::*;
#(
   parameter int LONG_LENGTH  = 839,
   parameter int SHORT_LENGTH = 139
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic             short_mode,
   input  logic [LEN_W-1:0] addr,
   output logic [ROM_W-1:0] rd_data
);

   localparam int LONG_AW  = $clog2(LONG_LENGTH);
   localparam int SHORT_AW = $clog2(SHORT_LENGTH);

   logic [ROM_W-1:0] long_rom  [LONG_LENGTH];
   logic [ROM_W-1:0] short_rom [SHORT_LENGTH];
   logic [ROM_W-1:0] rd_data_ff;

   for (genvar gi = 0; gi < LONG_LENGTH; gi++) begin : g_long
      localparam logic [ROM_W-1:0] WORD = zcg_sample_word(64'(gi), 64'(LONG_LENGTH));
      assign long_rom[gi] = WORD;
   end

   for (genvar gi = 0; gi < SHORT_LENGTH; gi++) begin : g_short
      localparam logic [ROM_W-1:0] WORD = zcg_sample_word(64'(gi), 64'(SHORT_LENGTH));
      assign short_rom[gi] = WORD;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (short_mode) begin
            rd_data_ff <= short_rom[addr[SHORT_AW-1:0]];
         end else begin
            rd_data_ff <= long_rom[addr[LONG_AW-1:0]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/zcg_dp.sv
module zcg_dp
   import zcg_pkg::*;
#(
   parameter int LONG_LENGTH  = 839,
   parameter int SHORT_LENGTH = 139
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                short_mode,
   input  logic                cache_flush,
   input  logic [ROOT_W-1:0]   in_root,
   input  logic [INDEX_W-1:0]  in_index,
   input  logic [SLOT_W-1:0]   in_slot,
   input  zcg_cmd_type         cmd,
   output zcg_status_type      status,
   output zcg_result_type      result,
   output logic                result_bad
);

   localparam logic [LEN_W-1:0] LONG_N  = LEN_W'(LONG_LENGTH);
   localparam logic [LEN_W-1:0] SHORT_N = LEN_W'(SHORT_LENGTH);

   // item registers
   logic [ROOT_W-1:0]  root_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               mode_ff;
   logic               bad_ff;
   logic [LEN_W-1:0]   inv_ff;

   // inverse cache
   logic [ROOT_W-1:0]  cached_root_ff;
   logic [LEN_W-1:0]   cached_inv_ff;
   logic               cache_valid_ff;
   logic               cache_valid_in;

   // inverse search: srch_acc = root * srch_t mod n
   logic [LEN_W-1:0]   srch_acc_ff;
   logic [LEN_W-1:0]   srch_t_ff;

   // modular multiplier
   logic [LEN_W-1:0]   mm_x_ff;
   logic [INDEX_W-1:0] mm_y_ff;
   logic [LEN_W-1:0]   mm_acc_ff;

   logic [LEN_W-1:0]   j_ff;
   logic [ROM_W-1:0]   rom_data;

   logic [LEN_W-1:0]   n_len;
   logic [LEN_W:0]     srch_sum;
   logic [LEN_W-1:0]   srch_next;
   logic [LEN_W:0]     mm_dbl;
   logic [LEN_W-1:0]   mm_dbl_red;
   logic [LEN_W:0]     mm_add;
   logic [LEN_W-1:0]   mm_next;
   logic [LEN_W:0]     succ;
   logic [LEN_W-1:0]   succ_red;
   logic [LEN_W:0]     half_sum;
   logic [LEN_W-1:0]   half_val;

   assign n_len = mode_ff ? SHORT_N : LONG_N;

   assign status.bad       = (root_ff == '0) || (root_ff >= n_len) || (index_ff >= n_len)
                             || !n_len[0];
   assign status.hit       = cache_valid_ff && (cached_root_ff == root_ff);
   assign status.found     = (srch_acc_ff == LEN_W'(1));
   assign status.exhausted = (srch_t_ff == (n_len - LEN_W'(1)));

   always_comb begin
      srch_sum  = {1'b0, srch_acc_ff} + {1'b0, root_ff};
      srch_next = (srch_sum >= {1'b0, n_len}) ? LEN_W'(srch_sum - {1'b0, n_len})
                                              : srch_sum[LEN_W-1:0];

      // acc = 2*acc + bit*x, both steps reduced once
      mm_dbl     = {mm_acc_ff, 1'b0};
      mm_dbl_red = (mm_dbl >= {1'b0, n_len}) ? LEN_W'(mm_dbl - {1'b0, n_len})
                                             : mm_dbl[LEN_W-1:0];
      mm_add     = {1'b0, mm_dbl_red} + (mm_y_ff[INDEX_W-1] ? {1'b0, mm_x_ff} : '0);
      mm_next    = (mm_add >= {1'b0, n_len}) ? LEN_W'(mm_add - {1'b0, n_len})
                                             : mm_add[LEN_W-1:0];

      succ     = {1'b0, mm_acc_ff} + (LEN_W + 1)'(1);
      succ_red = (succ >= {1'b0, n_len}) ? LEN_W'(succ - {1'b0, n_len}) : succ[LEN_W-1:0];

      // times inv(2) mod n (n odd): halve, adding n first when odd
      half_sum = {1'b0, mm_acc_ff} + (mm_acc_ff[0] ? {1'b0, n_len} : '0);
      half_val = half_sum[LEN_W:1];
   end

   always_comb begin
      cache_valid_in = cache_valid_ff;
      if (cache_flush) begin
         cache_valid_in = 1'b0;
      end else if (cmd.search && status.found) begin
         cache_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_valid_ff <= 1'b0;
         cached_root_ff <= '0;
         cached_inv_ff  <= '0;
      end else begin
         cache_valid_ff <= cache_valid_in;
         if (cmd.search && status.found) begin
            cached_root_ff <= root_ff;
            cached_inv_ff  <= srch_t_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         root_ff  <= in_root;
         index_ff <= in_index;
         slot_ff  <= in_slot;
         mode_ff  <= short_mode;
      end

      if (cmd.check) begin
         bad_ff      <= status.bad;
         inv_ff      <= cached_inv_ff;
         srch_acc_ff <= root_ff;
         srch_t_ff   <= LEN_W'(1);
      end else if (cmd.reject) begin
         bad_ff <= 1'b1;
      end

      if (cmd.search) begin
         if (status.found) begin
            inv_ff <= srch_t_ff;
         end else begin
            srch_acc_ff <= srch_next;
            srch_t_ff   <= srch_t_ff + LEN_W'(1);
         end
      end

      if (cmd.mm_start) begin
         mm_x_ff   <= (cmd.mm_sel == MM_INV_K) ? inv_ff : succ_red;
         mm_y_ff   <= index_ff;
         mm_acc_ff <= '0;
      end else if (cmd.mm_step) begin
         mm_acc_ff <= mm_next;
         mm_y_ff   <= mm_y_ff << 1;
      end

      if (cmd.halve) begin
         j_ff <= half_val;
      end
   end

   zcg_rom #(
      .LONG_LENGTH  (LONG_LENGTH),
      .SHORT_LENGTH (SHORT_LENGTH)
   ) u_rom (
      .clock      (clock),
      .rd_en      (cmd.rom_read),
      .short_mode (mode_ff),
      .addr       (j_ff),
      .rd_data    (rom_data)
   );

   assign result.sample_real = bad_ff ? '0 : $signed(rom_data[SAMPLE_W-1:0]);
   assign result.sample_imag = bad_ff ? '0 : $signed(rom_data[ROM_W-1:SAMPLE_W]);
   assign result.slot_out    = slot_ff;
   assign result.index_out   = index_ff;
   assign result_bad         = bad_ff;

   a_mm_acc_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mm_step |=> (mm_acc_ff < n_len))
      else $error("modular multiply accumulator left the residue range");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cmd.halve |=> (j_ff < n_len))
      else $error("phase index not below sequence length");

   a_reject_keeps_cache: assert property (@(posedge clock) disable iff (reset)
      (bad_ff && !cmd.load) |=> ($stable(cached_root_ff) && $stable(cached_inv_ff)))
      else $error("rejected item modified the inverse cache");

endmodule

FILE: hw/rtl/zcg_ctrl.sv
module zcg_ctrl
   import zcg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           out_free,
   input  zcg_status_type status,
   output logic           idle,
   output logic           out_load,
   output zcg_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_CHECK  = 10'b00_0000_0010,
      S_SEARCH = 10'b00_0000_0100,
      S_START1 = 10'b00_0000_1000,
      S_MUL1   = 10'b00_0001_0000,
      S_START2 = 10'b00_0010_0000,
      S_MUL2   = 10'b00_0100_0000,
      S_HALF   = 10'b00_1000_0000,
      S_READ   = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } zcg_state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MM_STEPS - 1);

   zcg_state_type     state_ff;
   zcg_state_type     state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      idle     = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.bad) begin
               state_in = S_DONE;
            end else if (status.hit) begin
               state_in = S_START1;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (status.found) begin
               state_in = S_START1;
            end else if (status.exhausted) begin
               // no inverse exists for this root
               cmd.reject = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_START1: begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = MM_INV_K;
            step_in      = '0;
            state_in     = S_MUL1;
         end
         S_MUL1: begin
            cmd.mm_step = 1'b1;
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = S_START2;
            end
         end
         S_START2: begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = MM_SUCC_K;
            step_in      = '0;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mm_step = 1'b1;
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = S_HALF;
            end
         end
         S_HALF: begin
            cmd.halve = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.rom_read = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded over a waiting transaction");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL1) || (state_ff == S_MUL2)) |-> (step_ff <= STEP_LAST))
      else $error("multiply step counter overran");

   a_search_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> !status.hit)
      else $error("inverse search running on a cached root");

endmodule

FILE: hw/rtl/zadoff_chu_dft_sample_generator.sv
// A cached root skips the inverse search; a new root first searches for inv(u), trying
//   candidates up to N-1 when none exists. A new request is taken only when idle, after
//   the response of the last one is loaded; the work is set by the two 10-step bit-serial
//   modular multiplies, which rejected inputs skip.
// Reset (synchronous, active high) selects the long length, clears the inverse
//   cache and empties the response register.
module zadoff_chu_dft_sample_generator
   import zcg_pkg::*;
#(
   parameter int LONG_LENGTH  = 839,
   parameter int SHORT_LENGTH = 139
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // root, sample_index, slot

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // sample_real, sample_imag, slot_out, index_out
   output logic                  rsp_tuser,   // bad_input

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data     // short_mode
);

   logic           short_mode_ff;
   logic           rsp_valid_ff;
   zcg_result_type rsp_data_ff;
   logic           rsp_bad_ff;

   logic           out_free;
   logic           out_load;
   logic           csr_write;
   zcg_cmd_type    cmd;
   zcg_status_type status;
   zcg_result_type result;
   logic           result_bad;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            short_mode_ff <= csr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
         rsp_bad_ff  <= result_bad;
      end
   end

   zcg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid),
      .out_free (out_free),
      .status   (status),
      .idle     (req_tready),
      .out_load (out_load),
      .cmd      (cmd)
   );

   zcg_dp #(
      .LONG_LENGTH  (LONG_LENGTH),
      .SHORT_LENGTH (SHORT_LENGTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .short_mode  (short_mode_ff),
      .cache_flush (csr_write),
      .in_root     (req_tdata[ROOT_W-1:0]),
      .in_index    (req_tdata[ROOT_W +: INDEX_W]),
      .in_slot     (req_tdata[ROOT_W + INDEX_W +: SLOT_W]),
      .cmd         (cmd),
      .status      (status),
      .result      (result),
      .result_bad  (result_bad)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_bad_ff;

endmodule
